// ===== rtl/odc_pkg.sv =====
// ----------------------------------------------------------------------------
// odc_pkg: shared constants and tables for the orthographic direction cosines
// Angle format, CORDIC table, fixed-point widths, register indexes.
// ----------------------------------------------------------------------------
package odc_pkg;

  localparam int ANGLE_BITS   = 32;
  localparam int OUT_BITS     = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int GUARD        = 8;
  localparam int CW           = 42;              // cordic x/y width (q2.38 plus headroom)
  localparam int OFRAC        = OUT_BITS - 2;
  localparam int ODN          = (OFRAC < 60) ? 60 - OFRAC : 0;
  localparam int OUP          = (OFRAC > 60) ? OFRAC - 60 : 0;
  localparam int UP_SHIFT     = (ANGLE_BITS > 32) ? ANGLE_BITS - 32 : 0;
  localparam int DN_SHIFT     = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
  localparam int STW          = $clog2(CORDIC_STEPS + 1);

  localparam logic signed [CW-1:0] KGAIN_G = CW'(64'sd652032874 <<< GUARD);
  localparam logic signed [31:0]   ONE30   = 32'sd1073741824;

  typedef enum logic [0:0] {
    REG_CENTER_LON = 1'b0,
    REG_CENTER_LAT = 1'b1
  } reg_index_t;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [31:0]           q30_t;
  typedef logic signed [OUT_BITS-1:0]   out_t;

  typedef struct packed {
    logic signed [CW-1:0]         x;
    logic signed [CW-1:0]         y;
    logic signed [ANGLE_BITS+1:0] z;
    logic                         flip;
  } cordic_t;

  function automatic logic [31:0] atan_raw(input logic [4:0] i);
    case (i)
      5'd0:  atan_raw = 32'h20000000; 5'd1:  atan_raw = 32'h12E4051D;
      5'd2:  atan_raw = 32'h09FB385B; 5'd3:  atan_raw = 32'h051111D4;
      5'd4:  atan_raw = 32'h028B0D43; 5'd5:  atan_raw = 32'h0145D7E1;
      5'd6:  atan_raw = 32'h00A2F61E; 5'd7:  atan_raw = 32'h00517C55;
      5'd8:  atan_raw = 32'h0028BE53; 5'd9:  atan_raw = 32'h00145F2E;
      5'd10: atan_raw = 32'h000A2F98; 5'd11: atan_raw = 32'h000517CC;
      5'd12: atan_raw = 32'h00028BE6; 5'd13: atan_raw = 32'h000145F3;
      5'd14: atan_raw = 32'h0000A2F9; 5'd15: atan_raw = 32'h0000517C;
      5'd16: atan_raw = 32'h000028BE; 5'd17: atan_raw = 32'h0000145F;
      5'd18: atan_raw = 32'h00000A2F; 5'd19: atan_raw = 32'h00000517;
      5'd20: atan_raw = 32'h0000028B; 5'd21: atan_raw = 32'h00000145;
      5'd22: atan_raw = 32'h000000A2; 5'd23: atan_raw = 32'h00000051;
      5'd24: atan_raw = 32'h00000028; 5'd25: atan_raw = 32'h00000014;
      5'd26: atan_raw = 32'h0000000A; 5'd27: atan_raw = 32'h00000005;
      5'd28: atan_raw = 32'h00000002; 5'd29: atan_raw = 32'h00000001;
      default: atan_raw = 32'h0;
    endcase
  endfunction

  function automatic logic signed [ANGLE_BITS+1:0] atan_ent(input logic [4:0] i);
    logic [32:0] t;
    t = ({1'b0, atan_raw(i)} + 33'(((64'd1 << DN_SHIFT) >> 1))) >> DN_SHIFT;
    atan_ent = (ANGLE_BITS + 2)'(t) <<< UP_SHIFT;
  endfunction

  function automatic angle_t to_angle(input logic signed [31:0] f);
    logic signed [63:0] s;
    s = 64'(f) >>> DN_SHIFT;
    to_angle = ANGLE_BITS'(s <<< UP_SHIFT);
  endfunction

  // quadrant fold into [-pi/2, pi/2]
  function automatic cordic_t cordic_init(input angle_t a);
    cordic_t c;
    logic signed [ANGLE_BITS+1:0] aw, q;
    aw = (ANGLE_BITS + 2)'(a);
    q  = (ANGLE_BITS + 2)'(1) <<< (ANGLE_BITS - 2);
    c.x = KGAIN_G;
    c.y = '0;
    c.flip = 1'b0;
    c.z = aw;
    if (aw > q) begin
      c.z = (q <<< 1) - aw;
      c.flip = 1'b1;
    end else if (aw < -q) begin
      c.z = -(q <<< 1) - aw;
      c.flip = 1'b1;
    end
    cordic_init = c;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input logic [4:0] i);
    cordic_t n;
    logic signed [CW-1:0] dx, dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    n = c;
    if (!c.z[ANGLE_BITS+1]) begin
      n.x = c.x - dx; n.y = c.y + dy; n.z = c.z - atan_ent(i);
    end else begin
      n.x = c.x + dx; n.y = c.y - dy; n.z = c.z + atan_ent(i);
    end
    cordic_step = n;
  endfunction

  function automatic q30_t round_q30(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + CW'(1 <<< (GUARD - 1))) >>> GUARD;
    if (r > CW'(ONE30)) r = CW'(ONE30);
    if (r < -CW'(ONE30)) r = -CW'(ONE30);
    round_q30 = 32'(r);
  endfunction

  function automatic out_t to_out(input logic signed [64:0] v);
    logic signed [64:0] lim, w, r;
    lim = 65'sd1 <<< 60;
    w = v;
    if (w > lim) w = lim;
    if (w < -lim) w = -lim;
    r = (w + 65'(((65'sd1 <<< ODN) >>> 1))) >>> ODN;
    to_out = OUT_BITS'(r <<< OUP);
  endfunction

endpackage

// ===== rtl/odc_if.sv =====
// ----------------------------------------------------------------------------
// odc_in_if / odc_out_if: valid-ready channels
// Position items in, direction cosine items out.
// ----------------------------------------------------------------------------
interface odc_in_if;
  logic                   valid;
  logic                   ready;
  logic signed [31:0]     point_lon;
  logic signed [31:0]     point_lat;
  logic                   last_point;
  modport source (output valid, point_lon, point_lat, last_point, input ready);
  modport sink   (input valid, point_lon, point_lat, last_point, output ready);
endinterface

interface odc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [odc_pkg::OUT_BITS-1:0]  dir_x;
  logic signed [odc_pkg::OUT_BITS-1:0]  dir_y;
  logic                                 last_out;
  modport source (output valid, dir_x, dir_y, last_out, input ready);
  modport sink   (input valid, dir_x, dir_y, last_out, output ready);
endinterface

// ===== rtl/odc_center.sv =====
// ----------------------------------------------------------------------------
// odc_center: centre registers and sequential sin/cos of the centre latitude
// One CORDIC step per cycle after a latitude write, paused by longitude writes.
// ----------------------------------------------------------------------------
module odc_center (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  output odc_pkg::angle_t           lon0,
  output odc_pkg::q30_t             sin0,
  output odc_pkg::q30_t             cos0
);
  odc_pkg::cordic_t          cs;
  logic [odc_pkg::STW-1:0]   step;
  logic                      busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      lon0 <= '0;
      sin0 <= '0;
      cos0 <= odc_pkg::ONE30;
      busy <= 1'b0;
      step <= '0;
    end else if (cfg_we && cfg_index == odc_pkg::REG_CENTER_LON) begin
      lon0 <= odc_pkg::to_angle(cfg_data);
    end else if (cfg_we && cfg_index == odc_pkg::REG_CENTER_LAT) begin
      cs   <= odc_pkg::cordic_init(odc_pkg::to_angle(cfg_data));
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (step == odc_pkg::STW'(odc_pkg::CORDIC_STEPS)) begin
        busy <= 1'b0;
        sin0 <= odc_pkg::round_q30(cs.y);
        cos0 <= cs.flip ? -odc_pkg::round_q30(cs.x) : odc_pkg::round_q30(cs.x);
      end else begin
        cs   <= odc_pkg::cordic_step(cs, step[4:0]);
        step <= step + 1'b1;
      end
    end
  end
endmodule

// ===== rtl/odc_cordic_pipe.sv =====
// ----------------------------------------------------------------------------
// odc_cordic_pipe: pipelined dual sin/cos, one rotation per stage
// Carries longitude difference and latitude rotations side by side.
// ----------------------------------------------------------------------------
module odc_cordic_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  odc_pkg::angle_t   dlon,
  input  odc_pkg::angle_t   lat,
  input  logic              in_last,
  output logic              out_valid,
  output odc_pkg::q30_t     sl,
  output odc_pkg::q30_t     cl,
  output odc_pkg::q30_t     sp,
  output odc_pkg::q30_t     cp,
  output logic              out_last
);
  localparam int N = odc_pkg::CORDIC_STEPS;
  odc_pkg::cordic_t a [N+1];
  odc_pkg::cordic_t b [N+1];
  logic             v [N+1];
  logic             l [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      a[0] <= odc_pkg::cordic_init(dlon);
      b[0] <= odc_pkg::cordic_init(lat);
      l[0] <= in_last;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        a[i+1] <= odc_pkg::cordic_step(a[i], 5'(i));
        b[i+1] <= odc_pkg::cordic_step(b[i], 5'(i));
        l[i+1] <= l[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[N];
    end
    if (en) begin
      sl <= odc_pkg::round_q30(a[N].y);
      cl <= a[N].flip ? -odc_pkg::round_q30(a[N].x) : odc_pkg::round_q30(a[N].x);
      sp <= odc_pkg::round_q30(b[N].y);
      cp <= b[N].flip ? -odc_pkg::round_q30(b[N].x) : odc_pkg::round_q30(b[N].x);
      out_last <= l[N];
    end
  end
endmodule

// ===== rtl/odc_project.sv =====
// ----------------------------------------------------------------------------
// odc_project: products, difference and output saturation
// Four register stages of multiply, round, multiply-subtract, clamp and round.
// ----------------------------------------------------------------------------
module odc_project (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  odc_pkg::q30_t     sl,
  input  odc_pkg::q30_t     cl,
  input  odc_pkg::q30_t     sp,
  input  odc_pkg::q30_t     cp,
  input  logic              in_last,
  input  odc_pkg::q30_t     sin0,
  input  odc_pkg::q30_t     cos0,
  output logic              out_valid,
  output odc_pkg::out_t     dir_x,
  output odc_pkg::out_t     dir_y,
  output logic              out_last
);
  logic                 v1, v2, v3;
  logic                 l1, l2, l3;
  logic signed [63:0]   x1, x2, x3, a1, a2, tp;
  odc_pkg::q30_t        cl1, cl2, t2;
  logic signed [64:0]   y3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; out_valid <= v3;
    end
    if (en) begin
      x1  <= cp * sl;
      a1  <= cos0 * sp;
      tp  <= sin0 * cp;
      cl1 <= cl;
      l1  <= in_last;
      x2  <= x1;
      a2  <= a1;
      t2  <= 32'((tp + 64'sd536870912) >>> 30);
      cl2 <= cl1;
      l2  <= l1;
      x3  <= x2;
      y3  <= 65'(a2) - t2 * cl2;
      l3  <= l2;
      dir_x    <= odc_pkg::to_out(65'(x3));
      dir_y    <= odc_pkg::to_out(y3);
      out_last <= l3;
    end
  end
endmodule

// ===== rtl/orthographic_direction_cosines_top.sv =====
// ----------------------------------------------------------------------------
// orthographic_direction_cosines_top: orthographic tangent-plane projection
// Streams sky positions to direction cosines about a configured centre.
//
// channel   dir  fields
// in        in   point_lon, point_lat, last_point
// out       out  dir_x, dir_y, last_out
// cfg       in   cfg_we, cfg_index, cfg_data
//
// one item per cycle; stages: fold, 30 cordic rotations, round, four
// product stages. a centre latitude write runs on its own sequential
// cordic. the pipeline stalls as a whole when out is held off and its
// output register is full. reset is synchronous and clears valid bits.
// ----------------------------------------------------------------------------
module orthographic_direction_cosines_top (
  input  logic               clk,
  input  logic               rst,
  odc_in_if.sink             in_ch,
  odc_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  odc_pkg::angle_t   lon0;
  odc_pkg::q30_t     sin0, cos0, sl, cl, sp, cp;
  odc_pkg::angle_t   dlon;
  logic              en, cv, cl_last;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign dlon = odc_pkg::to_angle(in_ch.point_lon) - lon0;

  odc_center u_center (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .lon0, .sin0, .cos0
  );

  odc_cordic_pipe u_cordic (
    .clk, .rst, .en,
    .in_valid (in_ch.valid),
    .dlon     (dlon),
    .lat      (odc_pkg::to_angle(in_ch.point_lat)),
    .in_last  (in_ch.last_point),
    .out_valid(cv),
    .sl, .cl, .sp, .cp,
    .out_last (cl_last)
  );

  odc_project u_proj (
    .clk, .rst, .en,
    .in_valid (cv),
    .sl, .cl, .sp, .cp,
    .in_last  (cl_last),
    .sin0, .cos0,
    .out_valid(out_ch.valid),
    .dir_x    (out_ch.dir_x),
    .dir_y    (out_ch.dir_y),
    .out_last (out_ch.last_out)
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.dir_x))
    else $error("result dropped under stall");
  a_xlim: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.dir_x <= (odc_pkg::out_t'(1) <<< odc_pkg::OFRAC)
                  && out_ch.dir_x >= -(odc_pkg::out_t'(1) <<< odc_pkg::OFRAC))
    else $error("dir_x outside unit range");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
endmodule

// ===== sim/odc_checker.sv =====
// ----------------------------------------------------------------------------
// odc_checker: direction cosine predictor and result comparison
// Follows centre register writes, predicts dir_x, dir_y and last_out for every
// accepted position and compares each accepted result against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module odc_checker
  import odc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  odc_in_if           in_mon,
  odc_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } cosines_t;

  localparam logic [31:0] ATAN_ANGLE [30] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};

  cosines_t    expected_cosines[$];
  logic [31:0] lon_centre;
  longint      lat_centre_sin, lat_centre_cos;

  assign outstanding = expected_cosines.size();

  function automatic longint to_q30(input longint v);
    longint r;
    r = (v + 128) >>> 8;
    if (r > 64'sd1073741824) r = 64'sd1073741824;
    if (r < -64'sd1073741824) r = -64'sd1073741824;
    return r;
  endfunction

  function automatic void angle_sin_cos(input logic [31:0] ang, output longint s,
                                        output longint c);
    longint qtr, a, x, y, z, dx, dy, t;
    bit flip;
    qtr = 64'sd1 <<< 30;
    a = longint'(signed'(ang));
    x = 64'sd652032874 * 256;
    y = 0;
    flip = 0;
    if (a > qtr) begin
      a = 2 * qtr - a;
      flip = 1;
    end else if (a < -qtr) begin
      a = -2 * qtr - a;
      flip = 1;
    end
    z = a;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      t = longint'(ATAN_ANGLE[i]);
      if (z >= 0) begin
        x -= dx; y += dy; z -= t;
      end else begin
        x += dx; y -= dy; z += t;
      end
    end
    s = to_q30(y);
    c = to_q30(x);
    if (flip) c = -c;
  endfunction

  function automatic logic [31:0] to_q2_30(input longint v);
    longint lim, r;
    lim = 64'sd1 <<< 60;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    r = (v + (64'sd1 <<< 29)) >>> 30;
    return r[31:0];
  endfunction

  function automatic cosines_t project_point(input logic [31:0] lon,
                                             input logic [31:0] lat, input logic last);
    cosines_t res;
    logic [31:0] dlon;
    longint sl, cl, sp, cp, t;
    dlon = lon - lon_centre;
    angle_sin_cos(dlon, sl, cl);
    angle_sin_cos(lat, sp, cp);
    t = (lat_centre_sin * cp + (64'sd1 <<< 29)) >>> 30;
    res.x = to_q2_30(cp * sl);
    res.y = to_q2_30(lat_centre_cos * sp - t * cl);
    res.last = last;
    return res;
  endfunction

  always @(posedge clk) begin
    cosines_t want;
    if (rst) begin
      lon_centre <= '0;
      lat_centre_sin <= 0;
      lat_centre_cos <= 64'sd1073741824;
      expected_cosines.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CENTER_LON) begin
          lon_centre <= cfg_data;
        end else if (cfg_index == REG_CENTER_LAT) begin
          longint s, c;
          angle_sin_cos(cfg_data, s, c);
          lat_centre_sin <= s;
          lat_centre_cos <= c;
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_cosines.push_back(project_point(in_mon.point_lon, in_mon.point_lat,
                                                 in_mon.last_point));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_cosines.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected item: x %h y %h last %b", out_mon.dir_x, out_mon.dir_y,
                     out_mon.last_out);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_cosines.pop_front();
          if (want.x !== out_mon.dir_x || want.y !== out_mon.dir_y
              || want.last !== out_mon.last_out) begin
            if (mismatches < 10)
              $display("mismatch: expected x %h y %h last %b, got x %h y %h last %b",
                       want.x, want.y, want.last, out_mon.dir_x, out_mon.dir_y,
                       out_mon.last_out);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: orthographic direction cosines block
// Drives directed and random sky positions across several tangent centres
// with random idling on both channels and one long output hold-off; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import odc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 45;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [0:0]  cfg_index = REG_CENTER_LON;
  logic [31:0] cfg_data = '0;
  int          mismatches, outstanding;
  int          cycles = 0;
  bit          quiet = 0;
  bit          hold_off = 0;

  odc_in_if  in_ch();
  odc_out_if out_ch();

  initial begin
    in_ch.valid = 0;
    in_ch.point_lon = '0;
    in_ch.point_lat = '0;
    in_ch.last_point = 0;
    out_ch.ready = 0;
  end

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  orthographic_direction_cosines_top DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  odc_checker checker_i (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver: stall bursts, one long hold-off on request
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_point(input logic [31:0] lon, input logic [31:0] lat,
                            input logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.point_lon <= lon;
    in_ch.point_lat <= lat;
    in_ch.last_point <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_centre(input reg_index_t idx, input logic [31:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_lat();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 32'h80000000)) - 32'sh40000000);
  endfunction

  task automatic random_points(input int count);
    for (int i = 0; i < count; i++)
      send_point($urandom(), random_lat(), $urandom_range(0, 1));
  endtask

  initial begin
    logic [31:0] lons[6] = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h40000000,
                             32'hC0000000, 32'h00000001};
    logic [31:0] lats[7] = '{32'h40000000, 32'hC0000000, 32'h0, 32'h7FFFFFFF,
                             32'h80000000, 32'h3FFFFFFF, 32'hFFFFFFFF};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset centre: exact unit cosine
    for (int i = 0; i < 6; i++)
      send_point(lons[i], lats[(i * 3) % 7], i[0]);
    for (int i = 0; i < 7; i++)
      send_point(lons[i % 6], lats[i], !i[0]);
    settle();

    // zero latitude written: cordic cosine instead of exact one
    write_centre(REG_CENTER_LAT, 32'h0);
    for (int i = 0; i < 6; i++) send_point(lons[i], lats[i], 1'b1);
    random_points(40);
    settle();

    write_centre(REG_CENTER_LON, 32'h80000000);
    write_centre(REG_CENTER_LAT, 32'hC0000000);
    random_points(80);
    settle();

    write_centre(REG_CENTER_LON, 32'h7FFFFFFF);
    write_centre(REG_CENTER_LAT, 32'h40000000);
    random_points(40);
    hold_off = 1;
    random_points(80);
    settle();

    // out of range centre latitude folds through the pole
    write_centre(REG_CENTER_LAT, 32'h9ABCDEF0);
    random_points(60);
    settle();

    for (int k = 0; k < 3; k++) begin
      write_centre(REG_CENTER_LON, $urandom());
      write_centre(REG_CENTER_LAT, random_lat());
      random_points(80);
      settle();
    end

    quiet = 1;
    random_points(60);
    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
